// ===== rtl/core/ilp_pkg.sv =====
// Shared types and codes for the integer literal parser.
// Holds character codes, suffix, status and type-class codes and the inter-stage structs.
// No dependencies.
package ilp_pkg;

   localparam int MAG_W = 64;

   // Suffix tracking codes.
   localparam logic [2:0] SFX_NONE = 3'd0;
   localparam logic [2:0] SFX_U    = 3'd1;
   localparam logic [2:0] SFX_UL   = 3'd2;
   localparam logic [2:0] SFX_ULL  = 3'd3;
   localparam logic [2:0] SFX_L    = 3'd4;
   localparam logic [2:0] SFX_LL   = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_FLOAT = 2'd2;

   // Type classes.
   localparam logic [2:0] TC_INT8   = 3'd0;
   localparam logic [2:0] TC_UINT8  = 3'd1;
   localparam logic [2:0] TC_INT16  = 3'd2;
   localparam logic [2:0] TC_UINT16 = 3'd3;
   localparam logic [2:0] TC_INT32  = 3'd4;
   localparam logic [2:0] TC_UINT32 = 3'd5;
   localparam logic [2:0] TC_INT64  = 3'd6;
   localparam logic [2:0] TC_UINT64 = 3'd7;

   // ASCII characters the parser recognizes.
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_UP_L  = 8'h4C;
   localparam logic [7:0] CH_UP_U  = 8'h55;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_E  = 8'h65;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_L  = 8'h6C;
   localparam logic [7:0] CH_LO_U  = 8'h75;
   localparam logic [7:0] CH_LO_X  = 8'h78;

   // Parser state captured at the last character of a literal.
   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic             overflowed;
      logic             is_negative;
      logic             digit_seen;
      logic             syntax_bad;
      logic             float_seen;
      logic [2:0]       suffix_state;
   } ilp_snap_type;

   // One finished result.
   typedef struct packed {
      logic [1:0]       status;
      logic [2:0]       type_class;
      logic [MAG_W-1:0] value_bits;
   } ilp_result_type;

endpackage

// ===== rtl/core/ilp_step.sv =====
// Per-character state update of the integer literal parser.
// Holds the running literal state and the snapshot register taken at the last character.
// Depends on ilp_pkg.
module ilp_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          char_code,
   input  logic                last_char,
   output ilp_pkg::ilp_snap_type snap
);
   import ilp_pkg::*;

   logic [MAG_W-1:0] magnitude_ff, magnitude_in;
   logic             overflowed_ff, overflowed_in;
   logic [1:0]       char_position_ff, char_position_in;
   logic             is_negative_ff, is_negative_in;
   logic             hex_mode_ff, hex_mode_in;
   logic             first_was_zero_ff, first_was_zero_in;
   logic             digit_seen_ff, digit_seen_in;
   logic [2:0]       suffix_state_ff, suffix_state_in;
   logic             suffix_upper_ff, suffix_upper_in;
   logic             syntax_bad_ff, syntax_bad_in;
   logic             float_seen_ff, float_seen_in;
   ilp_snap_type     snap_ff;

   logic             is_dec, is_hex_letter, is_digit, is_sfx, sfx_up, sfx_is_u;
   logic [3:0]       digit_val;
   logic [MAG_W+3:0] mac;

   assign is_dec = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign is_hex_letter = hex_mode_ff &&
      (((char_code >= CH_LO_A) && (char_code <= CH_LO_F)) ||
       ((char_code >= CH_UP_A) && (char_code <= CH_UP_F)));
   assign is_digit  = is_dec || is_hex_letter;
   // Letters a-f and A-F share the low nibble 1..6, so adding nine gives 10..15.
   assign digit_val = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);
   assign is_sfx    = (char_code == CH_UP_U) || (char_code == CH_LO_U) ||
                      (char_code == CH_UP_L) || (char_code == CH_LO_L);
   assign sfx_up    = (char_code == CH_UP_U) || (char_code == CH_UP_L);
   assign sfx_is_u  = (char_code == CH_UP_U) || (char_code == CH_LO_U);

   // Shift-add of one digit; any bit above the word means the value overflowed.
   assign mac = hex_mode_ff ?
      ({magnitude_ff, 4'b0000} + {{MAG_W{1'b0}}, digit_val}) :
      ({1'b0, magnitude_ff, 3'b000} + {3'b000, magnitude_ff, 1'b0} +
       {{MAG_W{1'b0}}, digit_val});

   always_comb begin
      magnitude_in      = magnitude_ff;
      overflowed_in     = overflowed_ff;
      is_negative_in    = is_negative_ff;
      hex_mode_in       = hex_mode_ff;
      first_was_zero_in = first_was_zero_ff;
      digit_seen_in     = digit_seen_ff;
      suffix_state_in   = suffix_state_ff;
      suffix_upper_in   = suffix_upper_ff;
      syntax_bad_in     = syntax_bad_ff;
      float_seen_in     = float_seen_ff;
      char_position_in  = (char_position_ff == 2'd3) ? 2'd3 : (char_position_ff + 2'd1);

      if ((char_code == CH_DOT) || (char_code == CH_LO_E) || (char_code == CH_UP_E)) begin
         float_seen_in = 1'b1;
      end else if (last_char && ((char_code == CH_LO_F) || (char_code == CH_UP_F))) begin
         float_seen_in = 1'b1;
      end else if ((char_position_ff == 2'd0) && (char_code == CH_MINUS)) begin
         is_negative_in = 1'b1;
      end else if ((char_position_ff == 2'd1) && first_was_zero_ff && !hex_mode_ff &&
                   (suffix_state_ff == SFX_NONE) &&
                   ((char_code == CH_LO_X) || (char_code == CH_UP_X))) begin
         hex_mode_in   = 1'b1;
         digit_seen_in = 1'b0;
      end else if (is_sfx) begin
         if (suffix_state_ff == SFX_NONE) begin
            suffix_state_in = sfx_is_u ? SFX_U : SFX_L;
            suffix_upper_in = sfx_up;
         end else if (sfx_is_u || (sfx_up != suffix_upper_ff)) begin
            syntax_bad_in = 1'b1;
         end else begin
            unique case (suffix_state_ff)
               SFX_U:   suffix_state_in = SFX_UL;
               SFX_UL:  suffix_state_in = SFX_ULL;
               SFX_L:   suffix_state_in = SFX_LL;
               default: syntax_bad_in = 1'b1;
            endcase
         end
      end else if (is_digit && (suffix_state_ff == SFX_NONE)) begin
         magnitude_in  = mac[MAG_W-1:0];
         overflowed_in = overflowed_ff || (mac[MAG_W+3:MAG_W] != 4'd0);
         digit_seen_in = 1'b1;
         if ((char_position_ff == 2'd0) && (char_code == CH_ZERO)) begin
            first_was_zero_in = 1'b1;
         end
      end else begin
         syntax_bad_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last_char)) begin
         magnitude_ff      <= '0;
         overflowed_ff     <= 1'b0;
         char_position_ff  <= 2'd0;
         is_negative_ff    <= 1'b0;
         hex_mode_ff       <= 1'b0;
         first_was_zero_ff <= 1'b0;
         digit_seen_ff     <= 1'b0;
         suffix_state_ff   <= SFX_NONE;
         suffix_upper_ff   <= 1'b0;
         syntax_bad_ff     <= 1'b0;
         float_seen_ff     <= 1'b0;
      end else if (take) begin
         magnitude_ff      <= magnitude_in;
         overflowed_ff     <= overflowed_in;
         char_position_ff  <= char_position_in;
         is_negative_ff    <= is_negative_in;
         hex_mode_ff       <= hex_mode_in;
         first_was_zero_ff <= first_was_zero_in;
         digit_seen_ff     <= digit_seen_in;
         suffix_state_ff   <= suffix_state_in;
         suffix_upper_ff   <= suffix_upper_in;
         syntax_bad_ff     <= syntax_bad_in;
         float_seen_ff     <= float_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && last_char) begin
         snap_ff.magnitude    <= magnitude_in;
         snap_ff.overflowed   <= overflowed_in;
         snap_ff.is_negative  <= is_negative_in;
         snap_ff.digit_seen   <= digit_seen_in;
         snap_ff.syntax_bad   <= syntax_bad_in;
         snap_ff.float_seen   <= float_seen_in;
         snap_ff.suffix_state <= suffix_state_in;
      end
   end

   assign snap = snap_ff;

endmodule

// ===== rtl/core/ilp_finish.sv =====
// Final classification of a parsed literal: status, smallest fitting type class (int64 for L/LL) and value bits.
// Purely combinational; sits between the snapshot register and the result register.
// Depends on ilp_pkg.
module ilp_finish (
   input  ilp_pkg::ilp_snap_type   snap,
   output ilp_pkg::ilp_result_type result
);
   import ilp_pkg::*;

   localparam logic [MAG_W-1:0] INT64_MAG_POS = {1'b0, {(MAG_W-1){1'b1}}};
   localparam logic [MAG_W-1:0] INT64_MAG_NEG = {1'b1, {(MAG_W-1){1'b0}}};

   function automatic logic [2:0] class_unsigned(input logic [MAG_W-1:0] m);
      if (m <= 64'h00000000_000000FF)      return TC_UINT8;
      else if (m <= 64'h00000000_0000FFFF) return TC_UINT16;
      else if (m <= 64'h00000000_FFFFFFFF) return TC_UINT32;
      else                                 return TC_UINT64;
   endfunction

   function automatic logic [2:0] class_plain_pos(input logic [MAG_W-1:0] m);
      if (m <= 64'h00000000_0000007F)      return TC_INT8;
      else if (m <= 64'h00000000_000000FF) return TC_UINT8;
      else if (m <= 64'h00000000_00007FFF) return TC_INT16;
      else if (m <= 64'h00000000_0000FFFF) return TC_UINT16;
      else if (m <= 64'h00000000_7FFFFFFF) return TC_INT32;
      else if (m <= 64'h00000000_FFFFFFFF) return TC_UINT32;
      else if (m <= INT64_MAG_POS)         return TC_INT64;
      else                                 return TC_UINT64;
   endfunction

   function automatic logic [2:0] class_plain_neg(input logic [MAG_W-1:0] m);
      if (m <= 64'h00000000_00000080)      return TC_INT8;
      else if (m <= 64'h00000000_00008000) return TC_INT16;
      else if (m <= 64'h00000000_80000000) return TC_INT32;
      else                                 return TC_INT64;
   endfunction

   logic is_unsigned_sfx;

   assign is_unsigned_sfx = (snap.suffix_state == SFX_U) || (snap.suffix_state == SFX_UL) ||
                            (snap.suffix_state == SFX_ULL);

   always_comb begin
      result.status     = ST_OK;
      result.type_class = TC_INT8;
      result.value_bits = '0;
      if (snap.float_seen) begin
         result.status = ST_FLOAT;
      end else if (snap.syntax_bad || !snap.digit_seen || snap.overflowed) begin
         result.status = ST_BAD;
      end else if (is_unsigned_sfx) begin
         if (snap.is_negative) begin
            result.status = ST_BAD;
         end else begin
            result.type_class = class_unsigned(snap.magnitude);
            result.value_bits = snap.magnitude;
         end
      end else if (snap.is_negative) begin
         if (snap.magnitude > INT64_MAG_NEG) begin
            result.status = ST_BAD;
         end else begin
            result.type_class = (snap.suffix_state == SFX_NONE) ?
                                class_plain_neg(snap.magnitude) : TC_INT64;
            result.value_bits = '0 - snap.magnitude;
         end
      end else if (snap.suffix_state == SFX_NONE) begin
         result.type_class = class_plain_pos(snap.magnitude);
         result.value_bits = snap.magnitude;
      end else if (snap.magnitude > INT64_MAG_POS) begin
         result.status = ST_BAD;
      end else begin
         result.type_class = TC_INT64;
         result.value_bits = snap.magnitude;
      end
   end

endmodule

// ===== rtl/core/integer_literal_parser.sv =====
// Integer literal parser, top level: stream handshakes, input register and result register.
// Instantiates ilp_step and ilp_finish; depends on ilp_pkg.
//
// The block takes one ASCII character of a C-style integer literal per transaction on the
// req_ channel, with req_tlast marking the final character, and returns one result
// transaction on the rsp_ channel for each literal: a status (ok, malformed or out of range,
// float notation), the smallest type class and the 64-bit value in two's complement. It
// accepts one character every clock cycle for as long as the result side keeps up; the
// throughput is set by the shift-add in the character update stage. On its way out a
// literal passes the input register, loaded by the accepting edge; the snapshot
// register, where the state update captures the literal's final state; and the result
// register, loaded through the classification logic. Each of these three registers
// can hold a transaction on its own, so the input side keeps flowing while a finished
// result waits to be taken, and only stalls once a second finished literal is waiting.
module integer_literal_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [1:0] status, [4:2] type_class, [68:5] value_bits
);
   import ilp_pkg::*;

   // Input register stage.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // Snapshot stage valid; the snapshot data lives inside the step unit.
   logic       snap_valid_ff, snap_valid_in;

   // Result register stage.
   logic           out_valid_ff, out_valid_in;
   ilp_result_type out_ff;

   ilp_snap_type   snap;
   ilp_result_type result;

   logic out_take, out_free, snap_take, snap_free, in_take, req_fire;

   // Each stage may advance when the stage after it is empty or being emptied.
   assign out_take  = out_valid_ff && rsp_tready;
   assign out_free  = !out_valid_ff || rsp_tready;
   assign snap_take = snap_valid_ff && out_free;
   assign snap_free = !snap_valid_ff || snap_take;
   // A character that does not end a literal never needs the snapshot slot.
   assign in_take   = in_valid_ff && (!in_last_ff || snap_free);
   assign req_tready = !in_valid_ff || in_take;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in   = req_fire ? 1'b1 : (in_take ? 1'b0 : in_valid_ff);
   assign snap_valid_in = (in_take && in_last_ff) ? 1'b1 : (snap_take ? 1'b0 : snap_valid_ff);
   assign out_valid_in  = snap_take ? 1'b1 : (out_take ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         snap_valid_ff <= snap_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (snap_take) begin
         out_ff <= result;
      end
   end

   ilp_step u_step (
      .clock     (clock),
      .reset     (reset),
      .take      (in_take),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .snap      (snap)
   );

   ilp_finish u_finish (
      .snap   (snap),
      .result (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.value_bits, out_ff.type_class, out_ff.status};

   // A consumed last character must always leave a snapshot behind.
   a_last_makes_snap: assert property (@(posedge clock) disable iff (reset)
      (in_take && in_last_ff) |=> snap_valid_ff)
      else $error("last character consumed without a snapshot");

   // A snapshot is held until the result register can take it.
   a_snap_held: assert property (@(posedge clock) disable iff (reset)
      (snap_valid_ff && !out_free) |=> (snap_valid_ff && $stable(snap)))
      else $error("snapshot lost while the result register was full");

   // A failed literal carries neither a type nor a value.
   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_ff.status != ST_OK)) |->
         ((out_ff.type_class == TC_INT8) && (out_ff.value_bits == '0)))
      else $error("nonzero value or class on a failed literal");

   // Only the three defined status codes are ever produced.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_ff.status == ST_OK) || (out_ff.status == ST_BAD) ||
                      (out_ff.status == ST_FLOAT)))
      else $error("undefined status code");

   // The input register refuses a character only while it holds one it cannot pass on.
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && snap_valid_ff && !out_free))
      else $error("input stalled without a full pipeline behind it");

endmodule
